// ===== rtl/heat_diffusion_stencil_pass_core_assert.svh =====
// Assertion macros shared by the stencil pass RTL
`ifndef HEAT_DIFFUSION_STENCIL_PASS_CORE_ASSERT_SVH
`define HEAT_DIFFUSION_STENCIL_PASS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define HDS_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hds check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define HDS_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hds check failed");

`endif

// ===== rtl/hds_pkg.sv =====
// Shared constants, codes and types of the stencil pass core
`default_nettype none

package hds_pkg;

    // Size defaults
    localparam int DEF_MAX_ROW_LENGTH = 1024;
    localparam int DEF_MAX_ROWS       = 4096;

    // Field widths
    localparam int LEVEL_W      = 32;
    localparam int ACC_W        = 48;
    localparam int ROW_LENGTH_W = 11;
    localparam int ROW_COUNT_W  = 13;
    localparam int GAIN_W       = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;

    // Register reset values
    localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RESET = 11'd1024;
    localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RESET  = 13'd1024;
    localparam logic [GAIN_W-1:0]       GAIN_RESET       = 16'd655;

    // Lower clamps of the grid size
    localparam int MIN_ROW_LENGTH = 3;
    localparam int MIN_ROWS       = 2;

    // Q0.16 gain: product is scaled back by 16 bits, rounded half up
    localparam int ROUND_SHIFT = 16;
    localparam int ROUND_HALF  = 32768;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROW_LENGTH = 2'd0,
        CFG_ROW_COUNT  = 2'd1,
        CFG_GAIN       = 2'd2
    } cfg_index_t;

    // Input word kinds
    typedef enum logic {
        KIND_CELL  = 1'b0,
        KIND_DRAIN = 1'b1
    } kind_t;

    // Stencil operands handed from the row window to the arithmetic pipe
    typedef struct packed {
        logic [LEVEL_W-1:0] centre;
        logic [LEVEL_W-1:0] up;
        logic [LEVEL_W-1:0] left;
        logic [LEVEL_W-1:0] right;
        logic [LEVEL_W-1:0] down;
        logic               last;
    } hds_operands_t;

endpackage

`default_nettype wire

// ===== rtl/hds_if.sv =====
// Valid/ready channels of the stencil pass core: cell input and result output
`default_nettype none

interface hds_in_if
    import hds_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output kind, output level, input ready);
    modport sink   (input valid, input kind, input level, output ready);
endinterface

interface hds_out_if
    import hds_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] new_level;
    logic [ACC_W-1:0]   change_total;
    logic               frame_end;

    modport source (output valid, output new_level, output change_total, output frame_end,
                    input ready);
    modport sink   (input valid, input new_level, input change_total, input frame_end,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/hds_row_window.sv =====
// Row stores, raster position tracking and stencil operand gathering
`default_nettype none
`include "heat_diffusion_stencil_pass_core_assert.svh"

module hds_row_window
    import hds_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
    parameter int MAX_ROWS       = DEF_MAX_ROWS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ROW_LENGTH_W-1:0] row_length,
    input  logic [ROW_COUNT_W-1:0]  row_count,
    hds_in_if.sink                  cell_in,
    input  logic                    pipe_free,
    output logic                    op_valid,
    output hds_operands_t           op
);

    localparam int COL_W   = $clog2(MAX_ROW_LENGTH);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int LIM_LW  = $clog2(MAX_ROW_LENGTH + 1);
    localparam int LEN_CW  = (LIM_LW > ROW_LENGTH_W) ? LIM_LW : ROW_LENGTH_W;
    localparam int LIM_RW  = $clog2(MAX_ROWS + 1);
    localparam int ROWS_CW = (LIM_RW > ROW_COUNT_W) ? LIM_RW : ROW_COUNT_W;
    localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(MAX_ROW_LENGTH - 1);

    // Row stores
    logic [LEVEL_W-1:0] upper_mem  [MAX_ROW_LENGTH];
    logic [LEVEL_W-1:0] middle_mem [MAX_ROW_LENGTH];

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               draining_reg, draining_next;
    logic               clearing_reg;
    logic [COL_W-1:0]   clr_addr_reg;
    logic [LEVEL_W-1:0] cur_mid_reg, cur_mid_next;
    logic [LEVEL_W-1:0] mid0_reg, mid0_next;
    logic [LEVEL_W-1:0] left_reg, left_next;
    logic [LEVEL_W-1:0] cur_up_reg;
    logic [LEVEL_W-1:0] nxt_mid_reg;

    logic [LEN_CW-1:0]  len_eff;
    logic [ROWS_CW-1:0] rows_eff;
    logic               accept;
    logic               is_cell;
    logic               step;
    logic               row_end;
    logic               last_row;
    logic [COL_W-1:0]   nxt_col;
    logic               upper_we, middle_we;
    logic [COL_W-1:0]   upper_wa, middle_wa, upper_ra, middle_ra;
    logic [LEVEL_W-1:0] upper_wd, middle_wd;
    logic               up_ok;

    // Grid size in use, clamped
    always_comb
    begin
        len_eff = LEN_CW'(row_length);
        if (len_eff < LEN_CW'(MIN_ROW_LENGTH))
        begin
            len_eff = LEN_CW'(MIN_ROW_LENGTH);
        end
        else if (len_eff > LEN_CW'(MAX_ROW_LENGTH))
        begin
            len_eff = LEN_CW'(MAX_ROW_LENGTH);
        end
    end

    always_comb
    begin
        rows_eff = ROWS_CW'(row_count);
        if (rows_eff < ROWS_CW'(MIN_ROWS))
        begin
            rows_eff = ROWS_CW'(MIN_ROWS);
        end
        else if (rows_eff > ROWS_CW'(MAX_ROWS))
        begin
            rows_eff = ROWS_CW'(MAX_ROWS);
        end
    end

    // Handshake and step qualification: out-of-phase words are swallowed
    assign cell_in.ready = !clearing_reg && pipe_free;
    assign accept        = cell_in.valid && cell_in.ready;
    assign is_cell       = (cell_in.kind == KIND_CELL);
    assign step          = accept && (is_cell ? !draining_reg : draining_reg);
    assign row_end       = (LEN_CW'(col_reg) + LEN_CW'(1)) >= len_eff;
    assign last_row      = (ROWS_CW'(row_reg) + ROWS_CW'(1)) >= rows_eff;
    assign nxt_col       = row_end ? '0 : COL_W'(col_reg + 1'b1);

    // Position and phase update
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        if (step)
        begin
            col_next = nxt_col;
            if (row_end)
            begin
                if (!is_cell)
                begin
                    row_next      = '0;
                    draining_next = 1'b0;
                end
                else if (last_row)
                begin
                    draining_next = 1'b1;
                end
                else
                begin
                    row_next = ROW_W'(row_reg + 1'b1);
                end
            end
        end
    end

    // Window registers: centre, left and the shadow of middle column 0
    always_comb
    begin
        cur_mid_next = cur_mid_reg;
        mid0_next    = mid0_reg;
        left_next    = left_reg;
        if (step)
        begin
            // at a wrap the current column is at least 2, so column 0 is not written now
            cur_mid_next = row_end ? mid0_reg : nxt_mid_reg;
            left_next    = cur_mid_reg;
            if (is_cell && (col_reg == '0))
            begin
                mid0_next = cell_in.level;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
            cur_mid_reg  <= '0;
            mid0_reg     <= '0;
            left_reg     <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            draining_reg <= draining_next;
            cur_mid_reg  <= cur_mid_next;
            mid0_reg     <= mid0_next;
            left_reg     <= left_next;
        end
    end

    // Clearing pass after reset: one entry of each store per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= COL_W'(clr_addr_reg + 1'b1);
            end
        end
    end

    // Store ports: upper takes the old middle value, middle the incoming cell
    assign upper_we  = clearing_reg || step;
    assign upper_wa  = clearing_reg ? clr_addr_reg : col_reg;
    assign upper_wd  = clearing_reg ? '0 : cur_mid_reg;
    assign middle_we = clearing_reg || (step && is_cell);
    assign middle_wa = clearing_reg ? clr_addr_reg : col_reg;
    assign middle_wd = clearing_reg ? '0 : cell_in.level;

    // Prefetch for the next column: upper at it, middle one beyond it
    assign upper_ra  = nxt_col;
    assign middle_ra = (nxt_col == LAST_ADDR) ? '0 : COL_W'(nxt_col + 1'b1);

    always_ff @(posedge clk)
    begin
        if (upper_we)
        begin
            upper_mem[upper_wa] <= upper_wd;
        end
        if (middle_we)
        begin
            middle_mem[middle_wa] <= middle_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_up_reg  <= '0;
            nxt_mid_reg <= '0;
        end
        else if (step)
        begin
            cur_up_reg  <= upper_mem[upper_ra];
            nxt_mid_reg <= middle_mem[middle_ra];
        end
    end

    // Operands of the new cell; the first row gives none
    assign up_ok    = is_cell ? (row_reg > ROW_W'(1)) : (row_reg != '0);
    assign op_valid = step && (!is_cell || (row_reg != '0));

    always_comb
    begin
        op.centre = cur_mid_reg;
        op.up     = up_ok ? cur_up_reg : '0;
        op.left   = (col_reg != '0) ? left_reg : '0;
        op.right  = row_end ? '0 : nxt_mid_reg;
        op.down   = is_cell ? cell_in.level : '0;
        op.last   = !is_cell && row_end;
    end

    // Checks
    `HDS_CHECK(a_wrap_far_from_start, step && row_end, (col_reg != '0) && (col_reg != COL_W'(1)))
    `HDS_CHECK(a_col_in_store, 1'b1, col_reg <= LAST_ADDR)
    `HDS_CHECK_NEXT(a_frame_restart, step && !is_cell && row_end,
                    (col_reg == '0) && (row_reg == '0) && !draining_reg)

endmodule

`default_nettype wire

// ===== rtl/hds_stencil_pipe.sv =====
// Stencil arithmetic pipeline with change accumulator and output register
`default_nettype none
`include "heat_diffusion_stencil_pass_core_assert.svh"

module hds_stencil_pipe
    import hds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [GAIN_W-1:0] gain,
    input  logic              op_valid,
    input  hds_operands_t     op,
    output logic              pipe_free,
    hds_out_if.source         cell_out
);

    localparam int SUM_W  = LEVEL_W + 2;
    localparam int LAP_W  = SUM_W + 1;
    localparam int MAG_W  = SUM_W;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int D_W    = RND_W - ROUND_SHIFT;
    localparam int RES_W  = D_W + 2;
    localparam int SUMA_W = ACC_W + 1;

    // Stage valids and load strobes
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic load1, load2, load3, load4, load5;

    // Stage 1: operands
    hds_operands_t op1_reg;
    // Stage 2: Laplacian magnitude
    logic [MAG_W-1:0]   mag2_reg;
    logic               neg2_reg, last2_reg;
    logic [LEVEL_W-1:0] centre2_reg;
    // Stage 3: scaled product
    logic [PROD_W-1:0]  prod3_reg;
    logic               neg3_reg, last3_reg;
    logic [LEVEL_W-1:0] centre3_reg;
    // Stage 4: rounded change
    logic [D_W-1:0]     d4_reg;
    logic               neg4_reg, last4_reg;
    logic [LEVEL_W-1:0] centre4_reg;
    // Output and accumulator
    logic [LEVEL_W-1:0] new_level_reg;
    logic [ACC_W-1:0]   change_total_reg;
    logic               frame_end_reg;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    logic [SUM_W-1:0]        nsum;
    logic signed [LAP_W-1:0] lap;
    logic                    lap_neg;
    logic [MAG_W-1:0]        lap_mag;
    logic [RND_W-1:0]        rnd;
    logic signed [RES_W-1:0] c_ext, d_ext, res;
    logic [LEVEL_W-1:0]      res_sat;
    logic [SUMA_W-1:0]       acc_sum;
    logic [ACC_W-1:0]        acc_sat;

    // Back-pressure chain
    assign load5     = !out_valid_reg || cell_out.ready;
    assign load4     = !v4_reg || load5;
    assign load3     = !v3_reg || load4;
    assign load2     = !v2_reg || load3;
    assign load1     = !v1_reg || load2;
    assign pipe_free = load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1) v1_reg        <= op_valid;
            if (load2) v2_reg        <= v1_reg;
            if (load3) v3_reg        <= v2_reg;
            if (load4) v4_reg        <= v3_reg;
            if (load5) out_valid_reg <= v4_reg;
        end
    end

    // Laplacian: four neighbours minus four times the centre
    always_comb
    begin
        nsum    = SUM_W'(op1_reg.up) + SUM_W'(op1_reg.left)
                + SUM_W'(op1_reg.right) + SUM_W'(op1_reg.down);
        lap     = $signed({1'b0, nsum}) - $signed({1'b0, op1_reg.centre, 2'b00});
        lap_neg = lap[LAP_W-1];
        lap_mag = lap_neg ? MAG_W'(-lap) : MAG_W'(lap);
    end

    // Round half away from zero on the magnitude
    assign rnd = RND_W'(prod3_reg) + RND_W'(ROUND_HALF);

    // Apply the change with saturation to the level range
    always_comb
    begin
        c_ext = $signed({{(RES_W - LEVEL_W){1'b0}}, centre4_reg});
        d_ext = $signed({2'b00, d4_reg});
        res   = neg4_reg ? (c_ext - d_ext) : (c_ext + d_ext);
        if (res[RES_W-1])
        begin
            res_sat = '0;
        end
        else if (res[RES_W-2:LEVEL_W] != '0)
        begin
            res_sat = '1;
        end
        else
        begin
            res_sat = res[LEVEL_W-1:0];
        end
    end

    // Saturating change accumulator
    always_comb
    begin
        acc_sum  = SUMA_W'(acc_reg) + SUMA_W'(d4_reg);
        acc_sat  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        acc_next = acc_reg;
        if (load5 && v4_reg)
        begin
            acc_next = last4_reg ? '0 : acc_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Stage payload registers
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            op1_reg <= op;
        end
        if (load2)
        begin
            mag2_reg    <= lap_mag;
            neg2_reg    <= lap_neg;
            centre2_reg <= op1_reg.centre;
            last2_reg   <= op1_reg.last;
        end
        if (load3)
        begin
            prod3_reg   <= PROD_W'(mag2_reg) * PROD_W'(gain);
            neg3_reg    <= neg2_reg;
            centre3_reg <= centre2_reg;
            last3_reg   <= last2_reg;
        end
        if (load4)
        begin
            d4_reg      <= rnd[RND_W-1:ROUND_SHIFT];
            neg4_reg    <= neg3_reg;
            centre4_reg <= centre3_reg;
            last4_reg   <= last3_reg;
        end
        if (load5)
        begin
            new_level_reg    <= res_sat;
            change_total_reg <= last4_reg ? acc_sat : '0;
            frame_end_reg    <= last4_reg;
        end
    end

    assign cell_out.valid        = out_valid_reg;
    assign cell_out.new_level    = new_level_reg;
    assign cell_out.change_total = change_total_reg;
    assign cell_out.frame_end    = frame_end_reg;

    // Checks
    `HDS_CHECK(a_total_only_at_end, cell_out.valid && !cell_out.frame_end,
               cell_out.change_total == '0)
    `HDS_CHECK_NEXT(a_acc_cleared, load5 && v4_reg && last4_reg, acc_reg == '0)
    `HDS_CHECK(a_empty_output_frees_pipe, !out_valid_reg, pipe_free)

endmodule

`default_nettype wire

// ===== rtl/heat_diffusion_stencil_pass_core.sv =====
// Top level of the five-point stencil diffusion pass: config registers and block wiring
//
//  Channel   Dir  Payload                               Handshake
//  cell_in   in   kind, level                           valid / ready
//  cell_out  out  new_level, change_total, frame_end    valid / ready
//  config    in   cfg_index, cfg_data                   cfg_we
//
// One word is taken per cycle while ready is high; cell_out is driven from registers.
// New cells trail the input by one row; drain words flush the last row.
// After reset a clearing pass zeroes both row stores entry by entry; ready is low.
// A stall on cell_out fills the five-stage arithmetic pipe, then ready drops.
`default_nettype none

module heat_diffusion_stencil_pass_core
    import hds_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
    parameter int MAX_ROWS       = DEF_MAX_ROWS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    hds_in_if.sink                 cell_in,
    hds_out_if.source              cell_out
);

    logic [ROW_LENGTH_W-1:0] row_length_reg;
    logic [ROW_COUNT_W-1:0]  row_count_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic                    pipe_free;
    logic                    op_valid;
    hds_operands_t           op;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_RESET;
            row_count_reg  <= ROW_COUNT_RESET;
            gain_reg       <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_LENGTH: row_length_reg <= cfg_data[ROW_LENGTH_W-1:0];
                CFG_ROW_COUNT:  row_count_reg  <= cfg_data[ROW_COUNT_W-1:0];
                CFG_GAIN:       gain_reg       <= cfg_data[GAIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Row stores and operand window
    hds_row_window #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROWS       (MAX_ROWS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_length (row_length_reg),
        .row_count  (row_count_reg),
        .cell_in    (cell_in),
        .pipe_free  (pipe_free),
        .op_valid   (op_valid),
        .op         (op)
    );

    // Arithmetic pipe and output register
    hds_stencil_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (gain_reg),
        .op_valid  (op_valid),
        .op        (op),
        .pipe_free (pipe_free),
        .cell_out  (cell_out)
    );

endmodule

`default_nettype wire

// ===== tb/sv/heat_diffusion_stencil_pass_checker.sv =====
// Predictor and scoreboard for the stencil pass core: watches config, cell and result channels
`default_nettype none

module heat_diffusion_stencil_pass_checker
    import hds_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
    parameter int MAX_ROWS       = DEF_MAX_ROWS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    hds_in_if                      cell_in,
    hds_out_if                     cell_out,
    output int unsigned            errors,
    output int unsigned            pending
);

    localparam longint unsigned CHANGE_CEIL = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint          LEVEL_CEIL  = 64'h0000_0000_FFFF_FFFF;
    localparam int unsigned     SHOWN_MISSES = 10;

    typedef struct packed {
        logic [LEVEL_W-1:0] new_level;
        logic [ACC_W-1:0]   change_total;
        logic               frame_end;
    } cell_result_t;

    // Predicted grid window and pass state
    logic [LEVEL_W-1:0]      upper_row  [MAX_ROW_LENGTH];
    logic [LEVEL_W-1:0]      middle_row [MAX_ROW_LENGTH];
    int unsigned             col_pos;
    int unsigned             row_pos;
    longint unsigned         change_sum;
    bit                      flushing;
    logic [ROW_LENGTH_W-1:0] row_length_q;
    logic [ROW_COUNT_W-1:0]  row_count_q;
    logic [GAIN_W-1:0]       gain_q;

    // New cells still owed by the block, oldest first
    cell_result_t            due_cells [$];
    cell_result_t            want;

    function automatic int unsigned span_in_use(int unsigned raw, int unsigned lo,
                                                int unsigned hi);
        if (raw < lo)
            return lo;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    // One new cell of output row o, column c; shifts the upper store
    function automatic logic [LEVEL_W-1:0] stencil_cell(int unsigned o, int unsigned c,
                                                        int unsigned len, longint below);
        longint          centre;
        longint          above;
        longint          west;
        longint          east;
        longint          lap;
        longint          res;
        longint unsigned mag;
        bit              neg;
        centre = middle_row[c];
        above  = (o > 0) ? upper_row[c] : 0;
        west   = (c > 0) ? upper_row[c - 1] : 0;
        east   = (c + 1 < len) ? middle_row[c + 1] : 0;
        lap    = above + west + east + below - 4 * centre;
        neg    = (lap < 0);
        mag    = neg ? -lap : lap;
        // round half away from zero on the magnitude
        mag    = (mag * gain_q + ROUND_HALF) >> ROUND_SHIFT;
        change_sum = change_sum + mag;
        if (change_sum > CHANGE_CEIL)
            change_sum = CHANGE_CEIL;
        res = neg ? centre - longint'(mag) : centre + longint'(mag);
        if (res < 0)
            res = 0;
        else if (res > LEVEL_CEIL)
            res = LEVEL_CEIL;
        upper_row[c] = middle_row[c];
        return res[LEVEL_W-1:0];
    endfunction

    // Advance the prediction by one accepted input word
    function automatic void predict_word(kind_t k, logic [LEVEL_W-1:0] lvl);
        int unsigned  len;
        int unsigned  c;
        bit           row_end;
        cell_result_t r;
        len     = span_in_use(row_length_q, MIN_ROW_LENGTH, MAX_ROW_LENGTH);
        c       = col_pos;
        row_end = (c + 1 >= len);
        if (c >= MAX_ROW_LENGTH)
            c = MAX_ROW_LENGTH - 1;
        r = '0;
        if (k == KIND_CELL) begin
            // cells are dropped while the last row flushes
            if (flushing)
                return;
            if (row_pos > 0) begin
                r.new_level = stencil_cell(row_pos - 1, c, len, longint'({32'd0, lvl}));
                due_cells.push_back(r);
            end
            else begin
                upper_row[c] = middle_row[c];
            end
            middle_row[c] = lvl;
            if (row_end) begin
                col_pos = 0;
                if (row_pos + 1 >= span_in_use(row_count_q, MIN_ROWS, MAX_ROWS))
                    flushing = 1'b1;
                else
                    row_pos = row_pos + 1;
            end
            else begin
                col_pos = c + 1;
            end
        end
        else if (flushing) begin
            r.new_level = stencil_cell(row_pos, c, len, 0);
            if (row_end) begin
                r.change_total = change_sum[ACC_W-1:0];
                r.frame_end    = 1'b1;
                col_pos        = 0;
                row_pos        = 0;
                change_sum     = 0;
                flushing       = 1'b0;
            end
            else begin
                col_pos = c + 1;
            end
            due_cells.push_back(r);
        end
    endfunction

    function automatic void report_miss(string what, logic [ACC_W-1:0] expected,
                                        logic [ACC_W-1:0] actual);
        errors = errors + 1;
        if (errors <= SHOWN_MISSES)
            $display("mismatch on %s: expected %h, actual %h", what, expected, actual);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            col_pos      = 0;
            row_pos      = 0;
            change_sum   = 0;
            flushing     = 1'b0;
            row_length_q = ROW_LENGTH_RESET;
            row_count_q  = ROW_COUNT_RESET;
            gain_q       = GAIN_RESET;
            due_cells.delete();
            errors       = 0;
        end
        else begin
            // register writes; an index with no register behind it is dropped
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROW_LENGTH: row_length_q = cfg_data[ROW_LENGTH_W-1:0];
                    CFG_ROW_COUNT:  row_count_q  = cfg_data[ROW_COUNT_W-1:0];
                    CFG_GAIN:       gain_q       = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (cell_in.valid && cell_in.ready)
                predict_word(kind_t'(cell_in.kind), cell_in.level);

            // compare each result word with the oldest one owed
            if (cell_out.valid && cell_out.ready) begin
                if (due_cells.size() == 0) begin
                    report_miss("unexpected word", '0, {16'd0, cell_out.new_level});
                end
                else begin
                    want = due_cells.pop_front();
                    if (want.new_level !== cell_out.new_level)
                        report_miss("new_level", {16'd0, want.new_level},
                                    {16'd0, cell_out.new_level});
                    if (want.change_total !== cell_out.change_total)
                        report_miss("change_total", want.change_total, cell_out.change_total);
                    if (want.frame_end !== cell_out.frame_end)
                        report_miss("frame_end", {47'd0, want.frame_end},
                                    {47'd0, cell_out.frame_end});
                end
            end
        end
        pending = due_cells.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/heat_diffusion_stencil_pass_core_test.sv =====
// Top of the stencil pass testbench: clock, reset, stimulus, result stalls and verdict
`default_nettype none

module heat_diffusion_stencil_pass_core_test;
    import hds_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned RANDOM_WORDS   = 750;
    // index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    hds_in_if  cells_in ();
    hds_out_if cells_out ();

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned idle_cycles = 0;
    int unsigned words_fed   = 0;
    bit          calm        = 1'b0;

    // Grid position as the sender sees it, to shape well-formed passes
    logic [ROW_LENGTH_W-1:0] seq_len_raw = ROW_LENGTH_RESET;
    logic [ROW_COUNT_W-1:0]  seq_rows_raw = ROW_COUNT_RESET;
    int unsigned             seq_col  = 0;
    int unsigned             seq_row  = 0;
    bit                      seq_flush = 1'b0;

    heat_diffusion_stencil_pass_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_in   (cells_in),
        .cell_out  (cells_out)
    );

    heat_diffusion_stencil_pass_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_in   (cells_in),
        .cell_out  (cells_out),
        .errors    (mismatches),
        .pending   (outstanding)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: cycles in a row with no word moved on either channel
    always @(posedge clk) begin
        if (!rst_n || (cells_in.valid && cells_in.ready) || (cells_out.valid && cells_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stall before each word, none while calm
    initial begin : result_sink
        int unsigned stall;
        cells_out.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                cells_out.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            cells_out.ready <= 1'b1;
            @(posedge clk);
            while (!cells_out.valid)
                @(posedge clk);
        end
    end

    function automatic int unsigned span_in_use(int unsigned raw, int unsigned lo,
                                                int unsigned hi);
        if (raw < lo)
            return lo;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    function automatic logic [LEVEL_W-1:0] draw_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return 32'hFFFF_0000 | $urandom_range(0, 65535);
            default: return 32'h7FFF_8000 + $urandom_range(0, 65535);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_word(input kind_t k, input logic [LEVEL_W-1:0] lvl);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            cells_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cells_in.valid <= 1'b1;
        cells_in.kind  <= k;
        cells_in.level <= lvl;
        @(posedge clk);
        while (!cells_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic feed_cell(input logic [LEVEL_W-1:0] lvl);
        offer_word(KIND_CELL, lvl);
        if (!seq_flush) begin
            words_fed++;
            if (seq_col + 1 >= span_in_use(seq_len_raw, MIN_ROW_LENGTH, DEF_MAX_ROW_LENGTH))
            begin
                seq_col = 0;
                if (seq_row + 1 >= span_in_use(seq_rows_raw, MIN_ROWS, DEF_MAX_ROWS))
                    seq_flush = 1'b1;
                else
                    seq_row++;
            end
            else begin
                seq_col++;
            end
        end
    endtask

    task automatic feed_drain();
        offer_word(KIND_DRAIN, $urandom);
        if (seq_flush) begin
            words_fed++;
            if (seq_col + 1 >= span_in_use(seq_len_raw, MIN_ROW_LENGTH, DEF_MAX_ROW_LENGTH))
            begin
                seq_col   = 0;
                seq_row   = 0;
                seq_flush = 1'b0;
            end
            else begin
                seq_col++;
            end
        end
    endtask

    // Hold off input until every owed word is out, then let the pipe empty
    task automatic quiesce();
        cells_in.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] word;
        // bits above the register width carry junk
        word = $urandom;
        case (idx)
            CFG_ROW_LENGTH:
            begin
                word[ROW_LENGTH_W-1:0] = value[ROW_LENGTH_W-1:0];
                seq_len_raw = value[ROW_LENGTH_W-1:0];
            end
            CFG_ROW_COUNT:
            begin
                word[ROW_COUNT_W-1:0] = value[ROW_COUNT_W-1:0];
                seq_rows_raw = value[ROW_COUNT_W-1:0];
            end
            CFG_GAIN:
            begin
                word = value[GAIN_W-1:0];
            end
            default: ;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // One grid pass with random content, stray words and now and then a resize mid-frame
    task automatic run_pass(input bit allow_break);
        int unsigned cut;
        int unsigned sent;
        cut  = 0;
        sent = 0;
        if (allow_break && $urandom_range(0, 5) == 0)
            cut = $urandom_range(1,
                span_in_use(seq_len_raw, MIN_ROW_LENGTH, DEF_MAX_ROW_LENGTH) *
                span_in_use(seq_rows_raw, MIN_ROWS, DEF_MAX_ROWS) - 1);
        while (!seq_flush) begin
            if (allow_break && $urandom_range(0, 29) == 0)
                feed_drain();
            feed_cell(draw_level());
            sent++;
            if (sent == cut && !seq_flush) begin
                quiesce();
                set_reg(CFG_ROW_LENGTH, $urandom_range(0, 12));
                set_reg(CFG_ROW_COUNT, $urandom_range(0, 6));
            end
        end
        while (seq_flush) begin
            if (allow_break && $urandom_range(0, 29) == 0)
                feed_cell(draw_level());
            feed_drain();
        end
    endtask

    initial begin : stimulus
        cells_in.valid = 1'b0;
        cells_in.kind  = KIND_CELL;
        cells_in.level = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Smallest grid after clamping, full gain: saturation at both ends,
        // a drain before the frame and a cell during the flush are dropped
        set_reg(CFG_ROW_LENGTH, 0);
        set_reg(CFG_ROW_COUNT, 1);
        set_reg(CFG_GAIN, 16'hFFFF);
        set_reg(CFG_SPARE, $urandom);
        feed_drain();
        feed_cell(32'hFFFF_FFFF);
        feed_cell(32'h0000_0000);
        feed_cell(32'hFFFF_FFFF);
        feed_cell(32'h0000_0000);
        feed_cell(32'hFFFF_FFFF);
        feed_cell(32'h0000_0000);
        feed_cell(32'h5555_AAAA);
        while (seq_flush)
            feed_drain();
        quiesce();

        // Resize mid-frame: column past the new row end, row on the new last row
        set_reg(CFG_ROW_LENGTH, 5);
        set_reg(CFG_ROW_COUNT, 3);
        set_reg(CFG_GAIN, 16'h8000);
        feed_cell(32'h7FFF_FFFF);
        feed_cell(32'h8000_0000);
        feed_cell(32'h0000_0001);
        feed_cell(32'hFFFF_FFFE);
        feed_cell(32'h1234_5678);
        feed_cell(32'hEDCB_A987);
        feed_cell(32'h0000_0000);
        feed_cell(32'hFFFF_FFFF);
        quiesce();
        set_reg(CFG_ROW_LENGTH, 3);
        set_reg(CFG_ROW_COUNT, 0);
        while (!seq_flush)
            feed_cell(draw_level());
        while (seq_flush)
            feed_drain();

        // Random passes on small grids
        while (words_fed < RANDOM_WORDS) begin
            quiesce();
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) != 0) begin
                set_reg(CFG_ROW_LENGTH, ($urandom_range(0, 9) == 0) ?
                        $urandom_range(13, 64) : $urandom_range(0, 12));
                set_reg(CFG_ROW_COUNT, $urandom_range(0, 6));
                case ($urandom_range(0, 3))
                    0:       set_reg(CFG_GAIN, 0);
                    1:       set_reg(CFG_GAIN, 16'hFFFF);
                    2:       set_reg(CFG_GAIN, $urandom_range(0, 65535));
                    default: set_reg(CFG_GAIN, $urandom_range(0, 4096));
                endcase
                if ($urandom_range(0, 7) == 0)
                    set_reg(CFG_SPARE, $urandom);
            end
            run_pass(1'b1);
        end

        quiesce();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
